/* rtl/iitf_pkg.sv */
package iitf_pkg;

    localparam int WORD_COUNT_DEF   = 4096;
    localparam int MAX_POSTINGS_DEF = 16;

    localparam int WORD_W   = 12;
    localparam int DOC_W    = 16;
    localparam int LEN_W    = 12;
    localparam int SLOT_W   = 4;
    localparam int WEIGHT_W = 17;
    localparam int STATUS_W = 2;
    localparam int LIST_W   = 5;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 17'h1FFFF;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_APPENDED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCUMULATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ_DONE   = 2'd3;

    localparam int OUT_VALID_BIT = LIST_W;

endpackage

/* rtl/iitf_ram.sv */
module iitf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/iitf_serdiv.sv */
module iitf_serdiv #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial     = {r_reg, q_reg[NUM_W-1]};
        ge        = trial >= {1'b0, d_reg};
        diff      = trial - {1'b0, d_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            q_next    = num;
            r_next    = '0;
            d_next    = den;
        end else if (busy_reg) begin
            q_next   = {q_reg[NUM_W-2:0], ge};
            r_next   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

/* rtl/inverted_index_tf_builder.sv */
// From request to result: the 17-step bit-serial reciprocal divider, the list-length
// read, a dispatch step, then a scan of the held postings (or a read of one held posting).
// One request at a time; the next is taken once the result is in the output register.
// A waiting result does not block the next request; only the next result waits.
// Reset is synchronous; afterwards a clearing pass zeroes the list-length memory
// at every word address, during which no request is taken.
module inverted_index_tf_builder
    import iitf_pkg::*;
#(
    parameter int WORD_COUNT   = WORD_COUNT_DEF,
    parameter int MAX_POSTINGS = MAX_POSTINGS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // word_index[11:0], document_id[27:12], document_length[39:28], slot[43:40]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // list_length[4:0], entry_valid[5], entry_document[21:6], entry_weight[38:22]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]    m_tuser
);

    localparam int WAW   = $clog2(WORD_COUNT);
    localparam int PDEP  = WORD_COUNT * MAX_POSTINGS;
    localparam int PAW   = $clog2(PDEP);
    localparam int NW    = $clog2(MAX_POSTINGS + 1);
    localparam int KW    = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
    localparam int CW    = (NW > SLOT_W) ? NW : SLOT_W;
    localparam int ENT_W = DOC_W + WEIGHT_W;

    localparam int     MOD_S  = WORD_W +
                                ((WORD_COUNT < (1 << WORD_W)) ? $clog2(WORD_COUNT) : 0);
    localparam longint MOD_M  = ((longint'(1) << MOD_S) + longint'(WORD_COUNT) - 1) /
                                longint'(WORD_COUNT);
    localparam int     MOD_MW = WORD_W + 2;
    localparam int     PROD_W = WORD_W + MOD_MW;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_CNT    = 3'd3;
    localparam logic [2:0] S_DISP   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_RDWAIT = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [WAW-1:0]         clr_reg, clr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]    m_tuser_reg, m_tuser_next;

    logic                   cmd_reg, cmd_next;
    logic [DOC_W-1:0]       doc_reg, doc_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [WORD_W-1:0]      wraw_reg, wraw_next;
    logic [WORD_W-1:0]      wquo_reg, wquo_next;
    logic [WAW-1:0]         word_reg, word_next;
    logic [WEIGHT_W-1:0]    inc_reg, inc_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [PAW-1:0]         base_reg, base_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [LIST_W-1:0]      res_len_reg, res_len_next;
    logic                   res_valid_reg, res_valid_next;
    logic [DOC_W-1:0]       res_doc_reg, res_doc_next;
    logic [WEIGHT_W-1:0]    res_weight_reg, res_weight_next;

    logic                   accept;
    logic [WORD_W-1:0]      in_word;
    logic [DOC_W-1:0]       in_doc;
    logic [LEN_W-1:0]       in_len;
    logic [LEN_W-1:0]       div_den;
    logic [SLOT_W-1:0]      in_slot;

    logic [PROD_W-1:0]      mod_prod;
    logic [PROD_W-1:0]      mod_shift;
    logic [PROD_W-1:0]      mod_back;
    logic [WORD_W-1:0]      mod_rem;
    logic [WAW-1:0]         word_mod;

    logic                   inc_busy;
    logic [WEIGHT_W-1:0]    inc_quot;

    logic                   cnt_we;
    logic [WAW-1:0]         cnt_waddr;
    logic [NW-1:0]          cnt_wdata;
    logic [NW-1:0]          cnt_rdata;

    logic                   post_we;
    logic [PAW-1:0]         post_waddr;
    logic [ENT_W-1:0]       post_wdata;
    logic [PAW-1:0]         post_raddr;
    logic [ENT_W-1:0]       post_rdata;
    logic [DOC_W-1:0]       rd_doc;
    logic [WEIGHT_W-1:0]    rd_weight;
    logic [WEIGHT_W:0]      sum;
    logic [WEIGHT_W-1:0]    sat_weight;
    logic [NW-1:0]          k_plus;

    assign in_word = s_tdata[WORD_W-1:0];
    assign in_doc  = s_tdata[WORD_W+DOC_W-1:WORD_W];
    assign in_len  = s_tdata[WORD_W+DOC_W+LEN_W-1:WORD_W+DOC_W];
    assign in_slot = s_tdata[WORD_W+DOC_W+LEN_W+SLOT_W-1:WORD_W+DOC_W+LEN_W];
    assign div_den = (in_len == '0) ? LEN_W'(1) : in_len;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // The word id is reduced by a reciprocal multiplication, then a multiply-back.
    assign mod_prod  = PROD_W'(in_word) * PROD_W'(MOD_M);
    assign mod_shift = mod_prod >> MOD_S;
    assign mod_back  = PROD_W'(wquo_reg) * PROD_W'(WORD_COUNT);
    assign mod_rem   = wraw_reg - mod_back[WORD_W-1:0];
    assign word_mod  = WAW'(mod_rem);

    iitf_serdiv #(.NUM_W(WEIGHT_W), .DEN_W(LEN_W)) u_inc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .num     (WEIGHT_ONE),
        .den     (div_den),
        .busy    (inc_busy),
        .quot    (inc_quot)
    );

    iitf_ram #(.WIDTH(NW), .DEPTH(WORD_COUNT)) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (word_mod),
        .rdata (cnt_rdata)
    );

    iitf_ram #(.WIDTH(ENT_W), .DEPTH(PDEP)) u_post_ram (
        .aclk  (aclk),
        .we    (post_we),
        .waddr (post_waddr),
        .wdata (post_wdata),
        .raddr (post_raddr),
        .rdata (post_rdata)
    );

    assign rd_doc     = post_rdata[ENT_W-1:WEIGHT_W];
    assign rd_weight  = post_rdata[WEIGHT_W-1:0];
    assign sum        = {1'b0, rd_weight} + {1'b0, inc_reg};
    assign sat_weight = sum[WEIGHT_W] ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
    assign k_plus     = NW'(k_reg) + NW'(1);

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        cmd_next        = cmd_reg;
        doc_next        = doc_reg;
        slot_next       = slot_reg;
        wraw_next       = wraw_reg;
        wquo_next       = wquo_reg;
        word_next       = word_reg;
        inc_next        = inc_reg;
        n_next          = n_reg;
        base_next       = base_reg;
        k_next          = k_reg;
        res_status_next = res_status_reg;
        res_len_next    = res_len_reg;
        res_valid_next  = res_valid_reg;
        res_doc_next    = res_doc_reg;
        res_weight_next = res_weight_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = word_reg;
        cnt_wdata       = n_reg + NW'(1);
        post_we         = 1'b0;
        post_waddr      = base_reg + PAW'(n_reg);
        post_wdata      = {doc_reg, inc_reg};
        post_raddr      = base_reg + PAW'(k_reg);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                cnt_wdata = '0;
                clr_next  = clr_reg + WAW'(1);
                if (clr_reg == WAW'(WORD_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = s_tuser;
                    doc_next   = in_doc;
                    slot_next  = in_slot;
                    wraw_next  = in_word;
                    wquo_next  = mod_shift[WORD_W-1:0];
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!inc_busy) begin
                    word_next  = word_mod;
                    inc_next   = inc_quot;
                    state_next = S_CNT;
                end
            end
            S_CNT: begin
                n_next     = cnt_rdata;
                base_next  = PAW'(word_reg) * PAW'(MAX_POSTINGS);
                state_next = S_DISP;
            end
            S_DISP: begin
                k_next = '0;
                if (cmd_reg == CMD_READ) begin
                    res_status_next = ST_READ_DONE;
                    res_len_next    = LIST_W'(n_reg);
                    if (CW'(slot_reg) < CW'(n_reg)) begin
                        post_raddr = base_reg + PAW'(slot_reg);
                        state_next = S_RDWAIT;
                    end else begin
                        res_valid_next  = 1'b0;
                        res_doc_next    = '0;
                        res_weight_next = '0;
                        state_next      = S_OUT;
                    end
                end else if (n_reg == '0) begin
                    post_we         = 1'b1;
                    cnt_we          = 1'b1;
                    res_status_next = ST_APPENDED;
                    res_len_next    = LIST_W'(n_reg + NW'(1));
                    res_valid_next  = 1'b1;
                    res_doc_next    = doc_reg;
                    res_weight_next = inc_reg;
                    state_next      = S_OUT;
                end else begin
                    post_raddr = base_reg;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                res_len_next = LIST_W'(n_reg);
                if (rd_doc == doc_reg) begin
                    post_we         = 1'b1;
                    post_waddr      = base_reg + PAW'(k_reg);
                    post_wdata      = {doc_reg, sat_weight};
                    res_status_next = ST_ACCUMULATED;
                    res_valid_next  = 1'b1;
                    res_doc_next    = doc_reg;
                    res_weight_next = sat_weight;
                    state_next      = S_OUT;
                end else if (k_plus < n_reg) begin
                    k_next     = k_plus[KW-1:0];
                    post_raddr = base_reg + PAW'(k_plus);
                end else if (n_reg == NW'(MAX_POSTINGS)) begin
                    res_status_next = ST_DROPPED;
                    res_valid_next  = 1'b0;
                    res_doc_next    = '0;
                    res_weight_next = '0;
                    state_next      = S_OUT;
                end else begin
                    post_we         = 1'b1;
                    cnt_we          = 1'b1;
                    res_status_next = ST_APPENDED;
                    res_len_next    = LIST_W'(n_reg + NW'(1));
                    res_valid_next  = 1'b1;
                    res_doc_next    = doc_reg;
                    res_weight_next = inc_reg;
                    state_next      = S_OUT;
                end
            end
            S_RDWAIT: begin
                res_valid_next  = 1'b1;
                res_doc_next    = rd_doc;
                res_weight_next = rd_weight;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {1'b0, res_weight_reg, res_doc_reg, res_valid_reg,
                                     res_len_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        cmd_reg        <= cmd_next;
        doc_reg        <= doc_next;
        slot_reg       <= slot_next;
        wraw_reg       <= wraw_next;
        wquo_reg       <= wquo_next;
        word_reg       <= word_next;
        inc_reg        <= inc_next;
        n_reg          <= n_next;
        base_reg       <= base_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_len_reg    <= res_len_next;
        res_valid_reg  <= res_valid_next;
        res_doc_reg    <= res_doc_next;
        res_weight_reg <= res_weight_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/iitf_checker.sv */
module iitf_checker
    import iitf_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser
);

    localparam int ENTRY_LSB = OUT_VALID_BIT + 1;

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s_tready)
        else $error("Result or ready raised right after reset.");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OUT_VALID_BIT] |-> m_tdata[OUT_TDATA_W-1:ENTRY_LSB] == '0)
        else $error("A result without a posting carries a nonzero document or weight.");

    a_touch_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_APPENDED || m_tuser == ST_ACCUMULATED)
            |-> m_tdata[OUT_VALID_BIT] && m_tdata[LIST_W-1:0] != '0)
        else $error("An append or accumulate result does not show a held posting.");

    a_drop_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DROPPED |-> !m_tdata[OUT_VALID_BIT])
        else $error("A dropped occurrence is marked as touching a posting.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("A stalled result changed or was withdrawn.");

endmodule

bind inverted_index_tf_builder iitf_checker u_iitf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import iitf_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_ITEMS  = 800;
    localparam int LONG_HOLD     = 800;
    localparam int HOT_WORDS     = 8;
    localparam int HOT_DOCS      = 24;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LIST_W-1:0]   list_length;
        logic                entry_valid;
        logic [DOC_W-1:0]    entry_document;
        logic [WEIGHT_W-1:0] entry_weight;
    } posting_result_t;

    class posting_list_model;
        logic [LIST_W-1:0]   list_len [WORD_COUNT_DEF];
        logic [DOC_W-1:0]    post_doc [WORD_COUNT_DEF * MAX_POSTINGS_DEF];
        logic [WEIGHT_W-1:0] post_weight [WORD_COUNT_DEF * MAX_POSTINGS_DEF];
        posting_result_t     awaited_results [$];
        int unsigned         mismatches;

        function new();
            foreach (list_len[i]) list_len[i] = '0;
            mismatches = 0;
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction

        function void apply_request(logic cmd, logic [WORD_W-1:0] word,
                                    logic [DOC_W-1:0] doc, logic [LEN_W-1:0] len,
                                    logic [SLOT_W-1:0] slot);
            posting_result_t     r;
            int                  base;
            int                  n;
            int                  k;
            bit                  hit;
            logic [LEN_W-1:0]    divisor;
            logic [WEIGHT_W-1:0] inc;
            logic [WEIGHT_W:0]   sum;
            base = int'(word) * MAX_POSTINGS_DEF;
            n = int'(list_len[word]);
            r = '0;
            r.list_length = LIST_W'(n);
            if (cmd == CMD_READ) begin
                r.status = ST_READ_DONE;
                if (int'(slot) < n) begin
                    r.entry_valid    = 1'b1;
                    r.entry_document = post_doc[base + int'(slot)];
                    r.entry_weight   = post_weight[base + int'(slot)];
                end
            end else begin
                divisor = (len == '0) ? LEN_W'(1) : len;
                inc = WEIGHT_ONE / divisor;
                hit = 1'b0;
                for (k = 0; k < n && !hit; k++) begin
                    if (post_doc[base + k] == doc) begin
                        sum = {1'b0, post_weight[base + k]} + {1'b0, inc};
                        if (sum > {1'b0, WEIGHT_MAX}) sum = {1'b0, WEIGHT_MAX};
                        post_weight[base + k] = sum[WEIGHT_W-1:0];
                        r.status         = ST_ACCUMULATED;
                        r.entry_valid    = 1'b1;
                        r.entry_document = doc;
                        r.entry_weight   = sum[WEIGHT_W-1:0];
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    if (n >= MAX_POSTINGS_DEF) begin
                        r.status = ST_DROPPED;
                    end else begin
                        post_doc[base + n]    = doc;
                        post_weight[base + n] = inc;
                        list_len[word]        = LIST_W'(n + 1);
                        r.status         = ST_APPENDED;
                        r.list_length    = LIST_W'(n + 1);
                        r.entry_valid    = 1'b1;
                        r.entry_document = doc;
                        r.entry_weight   = inc;
                    end
                end
            end
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_val, act_val);
            end
        endfunction

        function void match_result(logic [STATUS_W-1:0] status, logic [OUT_TDATA_W-1:0] data);
            posting_result_t e;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request waiting, status %0h, data %0h",
                         $time, status, data);
                return;
            end
            e = awaited_results.pop_front();
            compare_field("status", e.status, status);
            compare_field("list_length", e.list_length, data[LIST_W-1:0]);
            compare_field("entry_valid", e.entry_valid, data[OUT_VALID_BIT]);
            compare_field("entry_document", e.entry_document, data[OUT_VALID_BIT+1 +: DOC_W]);
            compare_field("entry_weight", e.entry_weight,
                          data[OUT_VALID_BIT+1+DOC_W +: WEIGHT_W]);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    posting_list_model postings = new();
    int unsigned       cycle_count = 0;
    int unsigned       results_seen = 0;
    int unsigned       requests_sent = 0;
    logic [WORD_W-1:0] hot_word [HOT_WORDS];
    logic [DOC_W-1:0]  hot_doc [HOT_DOCS];

    inverted_index_tf_builder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            postings.match_result(m_tuser, m_tdata);
            results_seen++;
        end
    end

    function automatic int idle_gap(bit quiet);
        int pick;
        if (quiet) return 0;
        pick = $urandom_range(0, 9);
        if (pick < 6) return 0;
        if (pick < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The sink counts its stalls itself; one long hold-off lets the block back up.
    initial begin : result_sink
        int  stall_left;
        bit  long_hold_done;
        bit  quiet;
        stall_left = 0;
        long_hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            quiet = ((results_seen / 100) % 3) == 1;
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 150) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                stall_left = idle_gap(quiet);
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with valid still high
    // only when the next request follows at once.
    task automatic send_request(input logic cmd, input logic [WORD_W-1:0] word,
                                input logic [DOC_W-1:0] doc, input logic [LEN_W-1:0] len,
                                input logic [SLOT_W-1:0] slot);
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, slot, len, doc, word};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        postings.apply_request(cmd, word, doc, len, slot);
        requests_sent++;
        @(negedge aclk);
        gap = idle_gap(((requests_sent / 100) % 3) == 2);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_random_request();
        logic              cmd;
        logic [WORD_W-1:0] word;
        logic [DOC_W-1:0]  doc;
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] slot;
        slot = SLOT_W'($urandom_range(0, 15));
        if ($urandom_range(0, 9) < 7) begin
            word = hot_word[$urandom_range(0, HOT_WORDS - 1)];
            cmd  = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_ADD;
            doc  = hot_doc[$urandom_range(0, HOT_DOCS - 1)];
            if ($urandom_range(0, 3) != 0) len = LEN_W'($urandom_range(1, 16));
            else len = LEN_W'($urandom_range(1, 4095));
        end else begin
            word = WORD_W'($urandom_range(0, 4095));
            cmd  = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_ADD;
            doc  = DOC_W'($urandom_range(0, 65535));
            len  = LEN_W'($urandom_range(1, 4095));
        end
        send_request(cmd, word, doc, len, slot);
    endtask

    initial begin : request_source
        int k;
        foreach (hot_word[i]) hot_word[i] = WORD_W'($urandom_range(0, 4095));
        foreach (hot_doc[i]) hot_doc[i] = DOC_W'($urandom_range(0, 65535));
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Saturating accumulation and a zero document length on the lowest word.
        send_request(CMD_ADD, 12'd0, 16'd0, 12'd1, 4'd0);
        send_request(CMD_ADD, 12'd0, 16'd0, 12'd1, 4'd15);
        send_request(CMD_ADD, 12'd0, 16'd0, 12'd0, 4'd0);
        send_request(CMD_ADD, 12'd0, 16'hFFFF, 12'd4095, 4'd0);
        send_request(CMD_READ, 12'd0, 16'd0, 12'd1, 4'd0);
        send_request(CMD_READ, 12'd0, 16'hFFFF, 12'd4095, 4'd1);
        send_request(CMD_READ, 12'd0, 16'd0, 12'd1, 4'd15);
        // Fill the highest word's list, then hit it with a new and a known document.
        for (k = 0; k < MAX_POSTINGS_DEF; k++) begin
            send_request(CMD_ADD, 12'd4095, DOC_W'(k * 4369),
                         (k == MAX_POSTINGS_DEF - 1) ? 12'd4095 : LEN_W'(k + 1), SLOT_W'(k));
        end
        send_request(CMD_ADD, 12'd4095, 16'd12345, 12'd7, 4'd0);
        send_request(CMD_ADD, 12'd4095, 16'hFFFF, 12'd3, 4'd0);
        send_request(CMD_READ, 12'd4095, 16'd0, 12'd1, 4'd15);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                s_tvalid <= 1'b0;
                while (postings.pending_count() != 0) @(negedge aclk);
                @(negedge aclk);
            end
            send_random_request();
        end
        s_tvalid <= 1'b0;

        while (postings.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (postings.mismatches == 0 && postings.pending_count() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
